[rtl/bom_pkg.sv]
// ----------------------------------------------------------------------------
// bom_pkg
// Shared types and constants for the BOM and UTF-8 encoding detector.
// ----------------------------------------------------------------------------
package bom_pkg;

    // Encoding codes returned with each result.
    typedef enum logic [2:0] {
        ENC_UTF8    = 3'd0,
        ENC_UTF16LE = 3'd1,
        ENC_UTF16BE = 3'd2,
        ENC_ASCII   = 3'd3,
        ENC_GBK     = 3'd4
    } encoding_t;

    // Confidence levels in whole percent.
    localparam logic [6:0] CONF_FULL  = 7'd100;
    localparam logic [6:0] CONF_HIGH  = 7'd80;
    localparam logic [6:0] CONF_HALF  = 7'd50;

    // Byte markers.
    localparam logic [7:0]  ASCII_MAX    = 8'h7F;
    localparam logic [15:0] UTF8_BOM_HI  = 16'hEFBB;
    localparam logic [7:0]  UTF8_BOM_LO  = 8'hBF;
    localparam logic [15:0] UTF16LE_BOM  = 16'hFFFE;
    localparam logic [15:0] UTF16BE_BOM  = 16'hFEFF;

    // Lead and continuation masks and patterns.
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;

    // Saturation point of the byte position count.
    localparam logic [1:0] POS_MAX = 2'd3;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_byte;
    } bom_item_t;

    // One result item.
    typedef struct packed {
        encoding_t  guess;
        logic [6:0] conf;
    } bom_result_t;

endpackage

[rtl/bom_in_if.sv]
// ----------------------------------------------------------------------------
// bom_in_if
// Valid/ready channel that carries one stream byte per transfer.
// ----------------------------------------------------------------------------
interface bom_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;

    modport source (output valid, output data_byte, output byte_present,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input last_byte, output ready);
endinterface

[rtl/bom_out_if.sv]
// ----------------------------------------------------------------------------
// bom_out_if
// Valid/ready channel that carries one encoding guess per transfer.
// ----------------------------------------------------------------------------
interface bom_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] encoding_guess;
    logic [6:0] confidence_pct;

    modport source (output valid, output encoding_guess, output confidence_pct,
                    input ready);
    modport sink   (input valid, input encoding_guess, input confidence_pct,
                    output ready);
endinterface

[rtl/bom_tracker.sv]
// ----------------------------------------------------------------------------
// bom_tracker
// Stream state (first bytes, BOM flag, UTF-8 structure) and the final guess.
// ----------------------------------------------------------------------------
module bom_tracker
    import bom_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  bom_item_t   item,
    output bom_result_t result
);

    logic [1:0]  pos_reg,   pos_next;
    logic [15:0] first_reg, first_next;
    logic        bom_reg,   bom_next;
    logic [1:0]  cont_reg,  cont_next;
    logic        inv_reg,   inv_next;
    logic        multi_reg, multi_next;

    logic [7:0]  b;
    logic        high_byte;
    logic        inv_final;

    assign b         = item.data_byte;
    assign high_byte = (b > ASCII_MAX);

    // Fold one byte into the stream state.
    always_comb
    begin
        pos_next   = pos_reg;
        first_next = first_reg;
        bom_next   = bom_reg;
        cont_next  = cont_reg;
        inv_next   = inv_reg;
        multi_next = multi_reg;
        if (item.byte_present)
        begin
            case (pos_reg)
                2'd0:    first_next = {b, 8'h00};
                2'd1:    first_next = {first_reg[15:8], b};
                2'd2:
                begin
                    if (first_reg == UTF8_BOM_HI && b == UTF8_BOM_LO)
                    begin
                        bom_next = 1'b1;
                    end
                end
                default: first_next = first_reg;
            endcase
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 2'd1;
            end
            if (high_byte)
            begin
                multi_next = 1'b1;
            end
            if (cont_reg != 2'd0)
            begin
                if ((b & CONT_MASK) == CONT_PAT)
                begin
                    cont_next = cont_reg - 2'd1;
                end
                else
                begin
                    inv_next  = 1'b1;
                    cont_next = 2'd0;
                end
            end
            else if (high_byte)
            begin
                if ((b & LEAD2_MASK) == LEAD2_PAT)
                begin
                    cont_next = 2'd1;
                end
                else if ((b & LEAD3_MASK) == LEAD3_PAT)
                begin
                    cont_next = 2'd2;
                end
                else if ((b & LEAD4_MASK) == LEAD4_PAT)
                begin
                    cont_next = 2'd3;
                end
                else
                begin
                    inv_next = 1'b1;
                end
            end
        end
    end

    // A sequence still owed at the end counts as broken.
    assign inv_final = inv_next | (cont_next != 2'd0);

    // Final guess from the updated state.
    always_comb
    begin
        if (pos_next == 2'd0)
        begin
            result = '{guess: ENC_UTF8, conf: CONF_FULL};
        end
        else if (pos_next == POS_MAX && bom_next)
        begin
            result = '{guess: ENC_UTF8, conf: CONF_FULL};
        end
        else if (pos_next >= 2'd2 && first_next == UTF16LE_BOM)
        begin
            result = '{guess: ENC_UTF16LE, conf: CONF_FULL};
        end
        else if (pos_next >= 2'd2 && first_next == UTF16BE_BOM)
        begin
            result = '{guess: ENC_UTF16BE, conf: CONF_FULL};
        end
        else if (!inv_final)
        begin
            if (multi_next)
            begin
                result = '{guess: ENC_UTF8, conf: CONF_HIGH};
            end
            else
            begin
                result = '{guess: ENC_ASCII, conf: CONF_FULL};
            end
        end
        else
        begin
            result = '{guess: ENC_GBK, conf: CONF_HALF};
        end
    end

    // State registers; the end of a stream returns everything to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 2'd0;
            first_reg <= 16'h0000;
            bom_reg   <= 1'b0;
            cont_reg  <= 2'd0;
            inv_reg   <= 1'b0;
            multi_reg <= 1'b0;
        end
        else if (take)
        begin
            if (item.last_byte)
            begin
                pos_reg   <= 2'd0;
                first_reg <= 16'h0000;
                bom_reg   <= 1'b0;
                cont_reg  <= 2'd0;
                inv_reg   <= 1'b0;
                multi_reg <= 1'b0;
            end
            else
            begin
                pos_reg   <= pos_next;
                first_reg <= first_next;
                bom_reg   <= bom_next;
                cont_reg  <= cont_next;
                inv_reg   <= inv_next;
                multi_reg <= multi_next;
            end
        end
    end

endmodule

[rtl/bom_and_utf8_encoding_detector_core.sv]
// ----------------------------------------------------------------------------
// bom_and_utf8_encoding_detector_core
// Guesses the encoding of a byte stream from its BOM and UTF-8 structure.
// ----------------------------------------------------------------------------
// Path: the last item waits in the input register, and the result register
// loads its guess when that item advances, which raises the output valid.
// Throughput: one item per cycle; a last item waits in the input register
// only while an earlier result is still held on the output.
// Reset: rst_n clears the stream state and both valid flags asynchronously.
// ----------------------------------------------------------------------------
module bom_and_utf8_encoding_detector_core
    import bom_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bom_in_if.sink    stream,
    bom_out_if.source verdict
);

    logic        in_valid_reg;
    bom_item_t   in_item_reg;
    logic        out_valid_reg;
    bom_result_t out_result_reg;

    bom_result_t result;
    logic        advance;
    logic        out_free;

    // The held item moves on when it makes no result or the result slot frees.
    assign out_free = !out_valid_reg || verdict.ready;
    assign advance  = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign stream.ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            in_item_reg <= '{data_byte:    stream.data_byte,
                             byte_present: stream.byte_present,
                             last_byte:    stream.last_byte};
        end
    end

    // Stream state and the guess.
    bom_tracker u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_item_reg.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdict.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_item_reg.last_byte)
        begin
            out_result_reg <= result;
        end
    end

    assign verdict.valid          = out_valid_reg;
    assign verdict.encoding_guess = out_result_reg.guess;
    assign verdict.confidence_pct = out_result_reg.conf;

endmodule
